### rtl/core/bsca_pkg.sv
// ----------------------------------------------------------------------------
// bsca_pkg
// shared types and codes for the banked slab chunk allocator
// ----------------------------------------------------------------------------
package bsca_pkg;

  localparam int HANDLE_W = 12;
  localparam int BYTES_W  = 16;
  localparam int STATUS_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REL   = 2'd2;

  // item modes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic init_step;
    logic start_alloc;
    logic start_rel;
    logic sel;
    logic take_null;
    logic link;
    logic fail_walk;
    logic walk_rd;
    logic walk_wr;
    logic res_alloc;
    logic res_fail;
    logic res_rel;
  } bsca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic any_free;
    logic first;
    logic more;
    logic walk_go;
    logic init_last;
  } bsca_stat_t;

endpackage

### rtl/core/banked_slab_chunk_allocator_top.sv
// ----------------------------------------------------------------------------
// banked_slab_chunk_allocator_top
// fixed-size chunk allocator over several banks of free rings
// ----------------------------------------------------------------------------
// Items are taken on start while busy is low; each item gives one result on
// status/handle/chunk_count, shown for exactly one cycle with done high, and
// the receiver must take it then since it cannot stall the block. One item is
// worked at a time. After reset the block is busy while it fills the free
// rings and clears the link table one entry a cycle. For each chunk an allocate
// does a bank pick and ring read, a link clear and a chain link, then gives its
// result; a release does a link read, then a link clear and ring give, for each
// chunk walked, then the end-of-chain check and the result.
// A failing allocate also walks back the chunks it already took. The single
// write port of the link table is shared by these steps.
module banked_slab_chunk_allocator_top #(
  parameter int NUM_BLOCKS       = 4,
  parameter int CHUNKS_PER_BLOCK = 512,
  parameter int CHUNK_BYTES      = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [bsca_pkg::BYTES_W-1:0]  request_bytes,
  input  logic [bsca_pkg::HANDLE_W-1:0] release_handle,
  output logic                          done,
  output logic [bsca_pkg::STATUS_W-1:0] status,
  output logic [bsca_pkg::HANDLE_W-1:0] handle,
  output logic [bsca_pkg::HANDLE_W-1:0] chunk_count
);

  // command and status between sequencer and datapath
  bsca_pkg::bsca_cmd_t  cmd;
  bsca_pkg::bsca_stat_t stat;

  // start only counts while idle
  logic start_ok;
  assign start_ok = start && !busy;

  bsca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start_ok),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bsca_datapath #(
    .NUM_BLOCKS       (NUM_BLOCKS),
    .CHUNKS_PER_BLOCK (CHUNKS_PER_BLOCK),
    .CHUNK_BYTES      (CHUNK_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .request_bytes  (request_bytes),
    .release_handle (release_handle),
    .status         (status),
    .handle         (handle),
    .chunk_count    (chunk_count)
  );

endmodule

### rtl/core/bsca_ctrl.sv
// ----------------------------------------------------------------------------
// bsca_ctrl
// sequencer for memory init, chunk takes and chain walks
// ----------------------------------------------------------------------------
module bsca_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                mode,
  input  bsca_pkg::bsca_stat_t stat,
  output bsca_pkg::bsca_cmd_t  cmd,
  output logic                busy,
  output logic                done
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SEL, S_NULLW, S_LINK, S_WALK_RD, S_WALK_WR
  } state_t;

  state_t state, state_next;
  logic   failed, failed_next;
  logic   done_next;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    failed_next = failed;
    done_next   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          failed_next = 1'b0;
          if (mode == bsca_pkg::MODE_RELEASE) begin
            cmd.start_rel = 1'b1;
            state_next    = S_WALK_RD;
          end else begin
            cmd.start_alloc = 1'b1;
            state_next      = S_SEL;
          end
        end
      end
      S_SEL: begin
        cmd.sel = 1'b1;
        if (stat.any_free) begin
          state_next = S_NULLW;
        end else if (stat.first) begin
          cmd.res_fail = 1'b1;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.fail_walk = 1'b1;
          failed_next   = 1'b1;
          state_next    = S_WALK_RD;
        end
      end
      S_NULLW: begin
        cmd.take_null = 1'b1;
        state_next    = S_LINK;
      end
      S_LINK: begin
        cmd.link = 1'b1;
        if (stat.more) begin
          state_next = S_SEL;
        end else begin
          cmd.res_alloc = 1'b1;
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_WALK_RD: begin
        if (stat.walk_go) begin
          cmd.walk_rd = 1'b1;
          state_next  = S_WALK_WR;
        end else begin
          cmd.res_fail = failed;
          cmd.res_rel  = !failed;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_WALK_WR: begin
        cmd.walk_wr = 1'b1;
        state_next  = S_WALK_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      failed <= 1'b0;
      busy   <= 1'b1;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      failed <= failed_next;
      busy   <= (state_next != S_IDLE);
      done   <= done_next;
    end
  end

endmodule

### rtl/core/bsca_datapath.sv
// ----------------------------------------------------------------------------
// bsca_datapath
// free rings, link table, bank counters and result registers
// ----------------------------------------------------------------------------
module bsca_datapath #(
  parameter int NUM_BLOCKS       = 4,
  parameter int CHUNKS_PER_BLOCK = 512,
  parameter int CHUNK_BYTES      = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bsca_pkg::bsca_cmd_t                  cmd,
  output bsca_pkg::bsca_stat_t                 stat,
  input  logic [bsca_pkg::BYTES_W-1:0]         request_bytes,
  input  logic [bsca_pkg::HANDLE_W-1:0]        release_handle,
  output logic [bsca_pkg::STATUS_W-1:0]        status,
  output logic [bsca_pkg::HANDLE_W-1:0]        handle,
  output logic [bsca_pkg::HANDLE_W-1:0]        chunk_count
);

  localparam int TOTAL = NUM_BLOCKS * CHUNKS_PER_BLOCK;
  localparam int GW    = $clog2(TOTAL + 1);
  localparam int AW    = $clog2(TOTAL);
  localparam int RW    = $clog2(2 * CHUNKS_PER_BLOCK);
  localparam int BW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int HW    = bsca_pkg::HANDLE_W;
  localparam int QW    = bsca_pkg::BYTES_W;
  localparam logic [GW-1:0] NullG = GW'(TOTAL);

  logic [GW-1:0] free_ring [TOTAL];
  logic [GW-1:0] next_link [TOTAL];
  logic [GW-1:0] ring_rdata, link_rdata;

  logic [RW-1:0] ring_head [NUM_BLOCKS];
  logic [RW-1:0] ring_tail [NUM_BLOCKS];
  logic [BW-1:0] rr;
  logic [AW-1:0] init_idx;

  logic [GW-1:0] cur, head_chunk, g_reg, count, walked;
  logic [QW-1:0] rem;
  logic          first, chained;

  function automatic logic [RW-1:0] slot_of(input logic [RW-1:0] c);
    slot_of = (c >= RW'(CHUNKS_PER_BLOCK)) ? c - RW'(CHUNKS_PER_BLOCK) : c;
  endfunction

  function automatic logic [RW-1:0] ctr_inc(input logic [RW-1:0] c);
    ctr_inc = (c == RW'(2 * CHUNKS_PER_BLOCK - 1)) ? '0 : c + 1'b1;
  endfunction

  // bank choice for a take
  logic [NUM_BLOCKS-1:0] nonempty;
  logic [BW-1:0]         sel_bank;
  logic [AW-1:0]         ring_raddr;
  logic                  any_free;

  always_comb begin
    sel_bank = '0;
    for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
      nonempty[b] = (ring_head[b] != ring_tail[b]);
    end
    for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
      if (nonempty[b]) sel_bank = BW'(b);
    end
    if (nonempty[rr]) sel_bank = rr;
    any_free   = |nonempty;
    ring_raddr = AW'(32'(sel_bank) * CHUNKS_PER_BLOCK + 32'(slot_of(ring_head[sel_bank])));
  end

  // bank of the chunk being given back
  logic [BW-1:0] give_bank;
  logic [RW-1:0] give_head, give_tail;
  logic [RW:0]   give_fill;
  logic          give_full;
  logic [AW-1:0] give_addr;

  always_comb begin
    give_bank = '0;
    for (int k = 1; k < NUM_BLOCKS; k++) begin
      if (32'(cur) >= k * CHUNKS_PER_BLOCK) give_bank = BW'(k);
    end
    give_head = ring_head[give_bank];
    give_tail = ring_tail[give_bank];
    if (give_tail >= give_head) begin
      give_fill = {1'b0, give_tail} - {1'b0, give_head};
    end else begin
      give_fill = {1'b0, give_tail} + (RW+1)'(2 * CHUNKS_PER_BLOCK) - {1'b0, give_head};
    end
    give_full = (give_fill == (RW+1)'(CHUNKS_PER_BLOCK));
    give_addr = AW'(32'(give_bank) * CHUNKS_PER_BLOCK + 32'(slot_of(give_tail)));
  end

  logic [GW-1:0] g_take;
  assign g_take = (32'(ring_rdata) >= TOTAL) ? '0 : ring_rdata;

  logic          walk_go;
  assign walk_go = (32'(cur) < TOTAL) && (32'(walked) < TOTAL);

  // link table write port
  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [GW-1:0] link_wdata;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = init_idx;
    link_wdata = NullG;
    if (cmd.init_step) begin
      link_we = 1'b1;
    end else if (cmd.take_null) begin
      link_we    = 1'b1;
      link_waddr = g_take[AW-1:0];
    end else if (cmd.link && chained) begin
      link_we    = 1'b1;
      link_waddr = cur[AW-1:0];
      link_wdata = g_reg;
    end else if (cmd.walk_wr) begin
      link_we    = 1'b1;
      link_waddr = cur[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) next_link[link_waddr] <= link_wdata;
    if (cmd.walk_rd) link_rdata <= next_link[cur[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      free_ring[init_idx] <= GW'(init_idx);
    end else if (cmd.walk_wr && !give_full) begin
      free_ring[give_addr] <= cur;
    end
    if (cmd.sel) ring_rdata <= free_ring[ring_raddr];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        ring_head[b] <= '0;
        ring_tail[b] <= RW'(CHUNKS_PER_BLOCK);
      end
      rr       <= '0;
      init_idx <= '0;
    end else begin
      if (cmd.init_step) init_idx <= init_idx + 1'b1;
      if (cmd.sel) begin
        rr <= (rr == BW'(NUM_BLOCKS - 1)) ? '0 : rr + 1'b1;
        if (any_free) ring_head[sel_bank] <= ctr_inc(ring_head[sel_bank]);
      end
      if (cmd.walk_wr && !give_full) ring_tail[give_bank] <= ctr_inc(give_tail);
    end
  end

  // per-item working registers and result
  always_ff @(posedge clk) begin
    if (cmd.start_alloc) begin
      rem   <= request_bytes;
      count <= '0;
      first <= 1'b1;
    end
    if (cmd.start_rel) begin
      cur    <= (32'(release_handle) >= TOTAL) ? NullG : GW'(release_handle);
      walked <= '0;
    end
    if (cmd.take_null) begin
      g_reg   <= g_take;
      chained <= !first;
      count   <= count + 1'b1;
      rem     <= (32'(rem) > CHUNK_BYTES) ? rem - QW'(CHUNK_BYTES) : '0;
      if (first) begin
        head_chunk <= g_take;
        cur        <= g_take;
        first      <= 1'b0;
      end
    end
    if (cmd.link && chained) cur <= g_reg;
    if (cmd.fail_walk) begin
      cur    <= head_chunk;
      walked <= '0;
    end
    if (cmd.walk_wr) begin
      cur    <= link_rdata;
      walked <= walked + 1'b1;
    end
    if (cmd.res_alloc) begin
      status      <= bsca_pkg::ST_ALLOC;
      handle      <= HW'(head_chunk);
      chunk_count <= HW'(count);
    end
    if (cmd.res_fail) begin
      status      <= bsca_pkg::ST_NOMEM;
      handle      <= HW'(NullG);
      chunk_count <= '0;
    end
    if (cmd.res_rel) begin
      status      <= bsca_pkg::ST_REL;
      handle      <= HW'(NullG);
      chunk_count <= HW'(walked);
    end
  end

  assign stat.any_free  = any_free;
  assign stat.first     = first;
  assign stat.more      = (rem != '0);
  assign stat.walk_go   = walk_go;
  assign stat.init_last = (init_idx == AW'(TOTAL - 1));

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the banked slab chunk allocator against a predictor of its own
// ----------------------------------------------------------------------------
// Items go in through start/busy and come back one result each on done. Every
// accepted item is run through an in-bench copy of the banks, rings and link
// table, and the result it gives is queued. The monitor compares each done
// cycle with the oldest entry of that queue. Stimulus keeps a list of live
// chain heads so most releases free real chains; the rest are noise.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NB    = 4;
  localparam int CPB   = 512;
  localparam int CB    = 64;
  localparam int TOTAL = NB * CPB;
  localparam int CMOD  = 2 * CPB;
  localparam int N_RANDOM = 830;
  localparam int STALL_LIMIT = 30000;
  localparam int PENDING_MAX = 8;

  typedef struct {
    logic                          mode;
    logic [bsca_pkg::BYTES_W-1:0]  nbytes;
    logic [bsca_pkg::HANDLE_W-1:0] rel;
  } alloc_req_t;

  typedef struct {
    logic [bsca_pkg::STATUS_W-1:0] status;
    logic [bsca_pkg::HANDLE_W-1:0] handle;
    logic [bsca_pkg::HANDLE_W-1:0] count;
  } alloc_res_t;

  logic clk, rst;
  logic start, busy, mode, done;
  logic [bsca_pkg::BYTES_W-1:0]  request_bytes;
  logic [bsca_pkg::HANDLE_W-1:0] release_handle;
  logic [bsca_pkg::STATUS_W-1:0] status;
  logic [bsca_pkg::HANDLE_W-1:0] handle, chunk_count;

  banked_slab_chunk_allocator_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .request_bytes(request_bytes), .release_handle(release_handle),
    .done(done), .status(status), .handle(handle), .chunk_count(chunk_count)
  );

  // predictor copy of the allocator state
  int pool_ring [TOTAL];
  int pool_link [TOTAL];
  int bank_head [NB];
  int bank_tail [NB];
  int rr_bank;

  alloc_req_t pending_items[$];
  alloc_res_t expected_results[$];
  int         live_heads[$];
  int         errors;
  int         idle_cycles;
  bit         stim_done;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int bank_fill(int b);
    return (bank_tail[b] + CMOD - bank_head[b]) % CMOD;
  endfunction

  function automatic int bank_pop(int b);
    int g;
    if (bank_fill(b) == 0) return TOTAL;
    g = pool_ring[b * CPB + bank_head[b] % CPB];
    if (g >= TOTAL) g = 0;
    bank_head[b] = (bank_head[b] + 1) % CMOD;
    pool_link[g] = TOTAL;
    return g;
  endfunction

  function automatic void bank_push(int g);
    int b;
    b = g / CPB;
    // full ring drops the chunk silently
    if (bank_fill(b) >= CPB) return;
    pool_ring[b * CPB + bank_tail[b] % CPB] = g;
    bank_tail[b] = (bank_tail[b] + 1) % CMOD;
  endfunction

  function automatic int grab_chunk();
    int first, g;
    first = rr_bank;
    rr_bank = (rr_bank + 1) % NB;
    g = bank_pop(first);
    if (g != TOTAL) return g;
    // fall back to the other banks in ascending order
    for (int b = 0; b < NB; b++) begin
      if (b == first) continue;
      g = bank_pop(b);
      if (g != TOTAL) return g;
    end
    return TOTAL;
  endfunction

  function automatic int walk_chain(int head);
    int cur, walked, nxt;
    cur = head;
    walked = 0;
    // walk is capped so a looping chain ends
    while (cur < TOTAL && walked < TOTAL) begin
      nxt = pool_link[cur];
      pool_link[cur] = TOTAL;
      bank_push(cur);
      walked++;
      cur = nxt;
    end
    return walked;
  endfunction

  function automatic alloc_res_t predict_result(alloc_req_t it);
    alloc_res_t r;
    int need, head, cur, nxt;
    r.handle = bsca_pkg::HANDLE_W'(TOTAL);
    r.count  = '0;
    if (it.mode == bsca_pkg::MODE_RELEASE) begin
      r.status = bsca_pkg::ST_REL;
      r.count  = bsca_pkg::HANDLE_W'(walk_chain(int'(it.rel)));
      return r;
    end
    r.status = bsca_pkg::ST_NOMEM;
    need = (int'(it.nbytes) + CB - 1) / CB;
    if (need == 0) need = 1;
    head = grab_chunk();
    if (head == TOTAL) return r;
    cur = head;
    for (int i = 1; i < need; i++) begin
      nxt = grab_chunk();
      if (nxt == TOTAL) begin
        // give back the partial chain
        void'(walk_chain(head));
        return r;
      end
      pool_link[cur] = nxt;
      cur = nxt;
    end
    r.status = bsca_pkg::ST_ALLOC;
    r.handle = bsca_pkg::HANDLE_W'(head);
    r.count  = bsca_pkg::HANDLE_W'(need);
    live_heads.insert(live_heads.size(), head);
    return r;
  endfunction

  // driver: bursts of items with random gaps between them
  int burst_left, gap_left;
  always @(posedge clk) begin
    alloc_req_t it;
    if (rst) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (start && !busy) begin
      it.mode = mode;
      it.nbytes = request_bytes;
      it.rel = release_handle;
      expected_results.insert(expected_results.size(), predict_result(it));
      if (burst_left > 0 && pending_items.size() > 0) begin
        it = pending_items.pop_front();
        mode <= it.mode;
        request_bytes <= it.nbytes;
        release_handle <= it.rel;
        burst_left <= burst_left - 1;
      end else begin
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        mode <= it.mode;
        request_bytes <= it.nbytes;
        release_handle <= it.rel;
        start <= 1'b1;
        burst_left <= $urandom_range(0, 20);
      end
    end
  end

  // monitor: done marks a result for exactly one cycle
  always @(posedge clk) begin
    alloc_res_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d handle %0d count %0d",
                 $time, status, handle, chunk_count);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
          errors++;
        end
        if (handle !== exp_r.handle) begin
          $display("%0t: handle expected %0d actual %0d", $time, exp_r.handle, handle);
          errors++;
        end
        if (chunk_count !== exp_r.count) begin
          $display("%0t: chunk_count expected %0d actual %0d",
                   $time, exp_r.count, chunk_count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake of either kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic queue_item(logic m, int nbytes, int rel);
    alloc_req_t it;
    it.mode = m;
    it.nbytes = bsca_pkg::BYTES_W'(nbytes);
    it.rel = bsca_pkg::HANDLE_W'(rel);
    pending_items.insert(pending_items.size(), it);
  endtask

  // wait for the previous items to be taken so live_heads is current
  task automatic drain_pending();
    while (pending_items.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
  endtask

  function automatic int pick_live();
    int k, h;
    k = $urandom_range(0, live_heads.size() - 1);
    h = live_heads[k];
    live_heads.delete(k);
    return h;
  endfunction

  initial begin
    int r, h;
    errors = 0;
    stim_done = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    mode = bsca_pkg::MODE_ALLOC;
    request_bytes = '0;
    release_handle = '0;
    for (int b = 0; b < NB; b++) begin
      bank_head[b] = 0;
      bank_tail[b] = CPB;
      for (int j = 0; j < CPB; j++) pool_ring[b * CPB + j] = b * CPB + j;
    end
    for (int j = 0; j < TOTAL; j++) pool_link[j] = TOTAL;
    rr_bank = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: size edges, pool exhaustion, null and odd releases
    queue_item(bsca_pkg::MODE_ALLOC, 0, 0);
    queue_item(bsca_pkg::MODE_ALLOC, 1, 4095);
    queue_item(bsca_pkg::MODE_ALLOC, CB, 0);
    queue_item(bsca_pkg::MODE_ALLOC, CB + 1, 0);
    queue_item(bsca_pkg::MODE_RELEASE, 65535, TOTAL);
    queue_item(bsca_pkg::MODE_RELEASE, 0, 4095);
    queue_item(bsca_pkg::MODE_ALLOC, 65535, 0);
    queue_item(bsca_pkg::MODE_ALLOC, 65535, 0);
    // too few chunks left for 65535 bytes: partial chain then failure
    queue_item(bsca_pkg::MODE_ALLOC, 65535, 0);
    queue_item(bsca_pkg::MODE_ALLOC, 5 * CB, 0);
    drain_pending();
    // free everything live, releasing each head twice (full ring drop)
    while (live_heads.size() > 0) begin
      h = pick_live();
      queue_item(bsca_pkg::MODE_RELEASE, 0, h);
      queue_item(bsca_pkg::MODE_RELEASE, 0, h);
      drain_pending();
    end
    // duplicates in a ring: release a free chunk while the bank is not full
    queue_item(bsca_pkg::MODE_ALLOC, 3 * CB, 0);
    drain_pending();
    h = pick_live();
    queue_item(bsca_pkg::MODE_RELEASE, 0, h);
    queue_item(bsca_pkg::MODE_RELEASE, 0, h);
    queue_item(bsca_pkg::MODE_ALLOC, 7 * CB, 0);
    queue_item(bsca_pkg::MODE_ALLOC, 7 * CB, 0);
    queue_item(bsca_pkg::MODE_RELEASE, 0, TOTAL - 1);
    drain_pending();

    // random part: mostly alloc/release of real chains, some noise
    for (int n = 0; n < N_RANDOM; n++) begin
      // queue up to PENDING_MAX + 1 items ahead so bursts can form
      while (pending_items.size() > PENDING_MAX) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_item(bsca_pkg::MODE_ALLOC, $urandom_range(0, 12 * CB), $urandom);
      end else if (r < 50) begin
        queue_item(bsca_pkg::MODE_ALLOC, $urandom_range(0, 65535), $urandom);
      end else if (r < 85 && live_heads.size() > 0) begin
        queue_item(bsca_pkg::MODE_RELEASE, $urandom, pick_live());
      end else if (r < 92) begin
        queue_item(bsca_pkg::MODE_RELEASE, $urandom, $urandom_range(0, 4095));
      end else begin
        queue_item(bsca_pkg::MODE_RELEASE, $urandom, $urandom_range(0, TOTAL - 1));
      end
    end

    drain_pending();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
